[rtl/core/modem_response_terminator_detector_macros.svh]
// Assertion macros for the modem response terminator detector.
`ifndef MODEM_RESPONSE_TERMINATOR_DETECTOR_MACROS_SVH
`define MODEM_RESPONSE_TERMINATOR_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MRTD_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MRTD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/core/mrtd_pkg.sv]
// Types and constants shared by the terminator detector modules.
package mrtd_pkg;

	localparam int MRTD_BUFFER_BYTES = 256;
	localparam int MRTD_QUEUE_DEPTH  = 4;
	localparam logic [15:0] MRTD_TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ERROR     = 3'd1,
		ST_PROMPT    = 3'd2,
		ST_NO_DATA   = 3'd3,
		ST_CORRUPTED = 3'd4
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       is_nul;
		logic       is_bad;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	localparam logic [47:0] TERM_OK    = {8'd13, 8'd10, 8'h4F, 8'h4B, 8'd13, 8'd10};
	localparam logic [71:0] TERM_ERROR = {8'd13, 8'd10, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52,
		8'd13, 8'd10};
	localparam logic [15:0] TERM_PROMPT = {8'h3E, 8'h20};

endpackage

[rtl/core/mrtd_front.sv]
// Front end: accepts input beats, decodes the operation and classifies the byte.
module mrtd_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [7:0]        rx_byte,
	input  mrtd_pkg::q_status_t q_stat,
	output logic              push,
	output mrtd_pkg::cmd_t    push_cmd
);
	import mrtd_pkg::*;

	op_t op;

	always_comb begin
		op = op_t'(operation);
		in_stall = q_stat.full;
		push = in_valid && !q_stat.full && (op != OP_NONE);
		push_cmd.op = op;
		push_cmd.data = rx_byte;
		push_cmd.is_nul = (rx_byte == 8'd0);
		push_cmd.is_bad = (rx_byte != 8'd13) && (rx_byte != 8'd10) &&
			((rx_byte < 8'd32) || (rx_byte > 8'd126));
	end

endmodule

[rtl/core/mrtd_queue.sv]
// Short command queue between the front end and the back end.
module mrtd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mrtd_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output mrtd_pkg::cmd_t      head_cmd,
	output mrtd_pkg::q_status_t q_stat
);
	import mrtd_pkg::*;

	localparam int PW = $clog2(MRTD_QUEUE_DEPTH);

	cmd_t          entry_q [MRTD_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_comb begin
		head_cmd = entry_q[rd_ptr_q];
		q_stat.empty = (count_q == '0);
		q_stat.full = (count_q == (PW+1)'(MRTD_QUEUE_DEPTH));
	end

endmodule

[rtl/core/mrtd_back.sv]
// Back end: read state, window compare, timeout and the result register.
module mrtd_back #(
	parameter int BUFFER_BYTES = mrtd_pkg::MRTD_BUFFER_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  mrtd_pkg::q_status_t q_stat,
	input  mrtd_pkg::cmd_t      head_cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          response_status,
	output logic [7:0]          bytes_captured
);
	import mrtd_pkg::*;

	localparam int CW = $clog2(BUFFER_BYTES);
	localparam int EW = (CW > 8) ? CW : 8;

	logic [15:0]   timeout_q;
	logic [71:0]   window_q, window_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   ticks_q, ticks_d;
	logic          active_q, active_d;
	logic          bad_q, bad_d;
	logic          nul_q, nul_d;

	logic          out_valid_q;
	status_t       status_q;
	logic [7:0]    captured_q;

	logic          res_vld;
	status_t       res_status;
	logic [EW-1:0] count_ext;
	logic [7:0]    res_count;
	logic [15:0]   ticks_inc;
	logic [71:0]   win_shift;
	logic [CW-1:0] count_inc;
	logic          nul_inc;
	logic          bad_inc;

	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	always_comb begin
		window_d = window_q;
		count_d = count_q;
		ticks_d = ticks_q;
		active_d = active_q;
		bad_d = bad_q;
		nul_d = nul_q;
		res_vld = 1'b0;
		res_status = ST_NO_DATA;
		win_shift = {window_q[63:0], head_cmd.data};
		count_inc = count_q + CW'(1);
		nul_inc = nul_q || head_cmd.is_nul;
		bad_inc = bad_q || head_cmd.is_bad;
		ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
		case (head_cmd.op)
			OP_START: begin
				window_d = '0;
				count_d = '0;
				ticks_d = '0;
				bad_d = 1'b0;
				nul_d = 1'b0;
				active_d = 1'b1;
				if (timeout_q == 16'd0) begin
					res_vld = 1'b1;
					active_d = 1'b0;
				end
			end
			OP_BYTE: begin
				if (active_q) begin
					window_d = win_shift;
					count_d = count_inc;
					nul_d = nul_inc;
					bad_d = bad_inc;
					if (!nul_inc && (win_shift[47:0] == TERM_OK)) begin
						res_vld = 1'b1;
						res_status = ST_OK;
					end else if (!nul_inc && (win_shift == TERM_ERROR)) begin
						res_vld = 1'b1;
						res_status = ST_ERROR;
					end else if (!nul_inc && (win_shift[15:0] == TERM_PROMPT)) begin
						res_vld = 1'b1;
						res_status = ST_PROMPT;
					end else if (count_inc >= CW'(BUFFER_BYTES - 1)) begin
						res_vld = 1'b1;
						res_status = bad_inc ? ST_CORRUPTED : ST_NO_DATA;
					end
					if (res_vld)
						active_d = 1'b0;
				end
			end
			OP_TICK: begin
				if (active_q) begin
					ticks_d = ticks_inc;
					if (ticks_inc >= timeout_q) begin
						res_vld = 1'b1;
						res_status = ((count_q != '0) && bad_q) ? ST_CORRUPTED : ST_NO_DATA;
						active_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		count_ext = EW'(count_d);
		res_count = (count_ext > EW'(255)) ? 8'hFF : count_ext[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= MRTD_TIMEOUT_RESET;
			window_q <= '0;
			count_q <= '0;
			ticks_q <= '0;
			active_q <= 1'b0;
			bad_q <= 1'b0;
			nul_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_wdata;
			if (pop) begin
				window_q <= window_d;
				count_q <= count_d;
				ticks_q <= ticks_d;
				active_q <= active_d;
				bad_q <= bad_d;
				nul_q <= nul_d;
			end
			if (pop && res_vld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_vld) begin
			status_q <= res_status;
			captured_q <= res_count;
		end
	end

	assign out_valid = out_valid_q;
	assign response_status = status_q;
	assign bytes_captured = captured_q;

endmodule

[rtl/core/modem_response_terminator_detector.sv]
// Top level of the modem response terminator detector.
//
// Input channel: in_valid/in_stall carry one beat of operation and rx_byte:
// start read, received byte or one millisecond tick. Operation 3 is dropped.
// Output channel: out_valid/out_stall carry response_status and
// bytes_captured, at most one beat per input beat, in input order.
// cfg_we/cfg_wdata write timeout_ticks (reset 1000); write only while idle.
// A beat that ends a read is written into the command queue, then the back end
// registers the result and raises out_valid. Throughput: one beat per cycle
// while out_stall holds no result; the back end updates the read state and
// compares the nine-byte window combinationally.
// A four-entry command queue sits between front and back end; while
// out_stall holds a result, the back end pauses and the queue fills, then
// in_stall rises until the result is taken.
// Reset clears the read state, the queue and the output valid; the block
// starts idle with no read armed.
module modem_response_terminator_detector #(
	parameter int BUFFER_BYTES = mrtd_pkg::MRTD_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  response_status,
	output logic [7:0]  bytes_captured
);
	import mrtd_pkg::*;

	`include "modem_response_terminator_detector_macros.svh"

	q_status_t q_stat;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head_cmd;
	logic      match_out;

	mrtd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.rx_byte   (rx_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	mrtd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	mrtd_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.q_stat          (q_stat),
		.head_cmd        (head_cmd),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.response_status (response_status),
		.bytes_captured  (bytes_captured)
	);

	assign match_out = out_valid && (response_status <= ST_PROMPT);

	`MRTD_ASSERT_SAME(a_status_range, out_valid, response_status <= ST_CORRUPTED, "bad status code")
	`MRTD_ASSERT_SAME(a_match_len, match_out, bytes_captured >= 8'd2, "match under two bytes")
	`MRTD_ASSERT_NEXT(a_push_lands, q_stat.empty && push, !q_stat.empty, "queued beat lost")
	`MRTD_ASSERT_SAME(a_no_pop_empty, q_stat.empty, !pop, "pop from empty queue")

endmodule
